/* sv/quadrature_click_counter_assert.svh */
// Assertion macros for the quadrature click counter.
`ifndef QUADRATURE_CLICK_COUNTER_ASSERT_SVH
`define QUADRATURE_CLICK_COUNTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on the rising clock edge outside reset.
`define QCC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");
// Next-cycle implication.
`define QCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");
// Property that holds in every cycle outside reset.
`define QCC_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: label");
`else
`define QCC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define QCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`define QCC_ASSERT_ALWAYS(label, clk, rst, prop)
`endif
`endif

/* sv/qcc_pkg.sv */
// Shared types, constants and the quadrature step table for the click counter.
`default_nettype none
package qcc_pkg;

   localparam int NumEncoders = 2;
   localparam int DivSteps    = 8;
   localparam int DivCntWidth = $clog2(DivSteps);

   // Command codes
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_INIT   = 2'd2;

   // Configuration register indexes
   localparam logic CSR_PULSES_PER_CLICK = 1'b0;
   localparam logic CSR_INVERT_MASK      = 1'b1;

   localparam logic [4:0] PpcReset    = 5'd4;
   localparam logic [1:0] InvertReset = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic       encoder_index;
      logic       a_level;
      logic       b_level;
   } req_item_type;

   typedef struct packed {
      logic signed [7:0] clicks;
      logic              clicks_encoder;
   } rsp_item_type;

   // Controller to datapath commands
   typedef struct packed {
      logic capture;
      logic update;
      logic div_step;
      logic finish;
   } qcc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_read;
      logic rsp_busy;
   } qcc_status_type;

   // Step from previous phase to current phase, phase = {B, A}.
   function automatic logic signed [1:0] qcc_step(input logic [1:0] prev,
                                                  input logic [1:0] cur);
      logic signed [1:0] s;
      case ({prev, cur})
         4'b00_01: s = -2'sd1;
         4'b00_10: s =  2'sd1;
         4'b01_00: s =  2'sd1;
         4'b01_11: s = -2'sd1;
         4'b10_00: s = -2'sd1;
         4'b10_11: s =  2'sd1;
         4'b11_01: s =  2'sd1;
         4'b11_10: s = -2'sd1;
         default:  s =  2'sd0;
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

/* sv/qcc_ctrl.sv */
// Controller state machine for the quadrature click counter.
`default_nettype none
module qcc_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire qcc_pkg::qcc_status_type status,
   output qcc_pkg::qcc_cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_FINISH
   } state_type;

   state_type                         state_ff, state_in;
   logic [qcc_pkg::DivCntWidth-1:0]   cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.update = 1'b1;
            cnt_in     = '0;
            state_in   = status.is_read ? ST_DIVIDE : ST_IDLE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == qcc_pkg::DivCntWidth'(qcc_pkg::DivSteps - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!status.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule
`default_nettype wire

/* sv/qcc_datapath.sv */
// Datapath: encoder state, configuration, shift-subtract divider, output register.
`default_nettype none
module qcc_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire qcc_pkg::req_item_type  req_item,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [4:0]             csr_wdata,
   input  wire qcc_pkg::qcc_cmd_type   cmd,
   output qcc_pkg::qcc_status_type     status,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output qcc_pkg::rsp_item_type       rsp_item
);

   qcc_pkg::req_item_type item_ff, item_in;
   logic [4:0]            ppc_ff, ppc_in;
   logic [1:0]            inv_ff, inv_in;
   logic [1:0]            phase_ff [qcc_pkg::NumEncoders];
   logic [1:0]            phase_in [qcc_pkg::NumEncoders];
   logic signed [7:0]     count_ff [qcc_pkg::NumEncoders];
   logic signed [7:0]     count_in [qcc_pkg::NumEncoders];
   logic signed [7:0]     remain_ff [qcc_pkg::NumEncoders];
   logic signed [7:0]     remain_in [qcc_pkg::NumEncoders];
   logic [7:0]            div_mag_ff, div_mag_in;
   logic [4:0]            div_rem_ff, div_rem_in;
   logic [4:0]            div_d_ff, div_d_in;
   logic                  div_neg_ff, div_neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   qcc_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   logic                  idx;
   logic                  enc_ok;
   logic [1:0]            cur_phase;
   logic signed [1:0]     step;
   logic signed [8:0]     step_sum;
   logic signed [8:0]     sum;
   logic [8:0]            mag;
   logic [5:0]            trial;
   logic                  qbit;
   logic signed [7:0]     clicks_sat;
   logic signed [7:0]     rem_signed;

   assign idx       = item_ff.encoder_index;
   assign enc_ok    = (32'(idx) < qcc_pkg::NumEncoders);
   assign cur_phase = {item_ff.b_level, item_ff.a_level};

   always_comb begin
      step = qcc_pkg::qcc_step(phase_ff[idx], cur_phase);
      if (inv_ff[idx]) begin
         step = -step;
      end
      step_sum = 9'(count_ff[idx]) + 9'(step);
      sum      = enc_ok ? (9'(remain_ff[idx]) + 9'(count_ff[idx])) : 9'sd0;
      mag      = sum[8] ? 9'(-sum) : 9'(sum);
      trial    = {div_rem_ff, div_mag_ff[7]};
      qbit     = (trial >= {1'b0, div_d_ff});
      // truncate toward zero: divide magnitudes, then restore sign
      if (div_neg_ff) begin
         clicks_sat = (div_mag_ff >= 8'd128) ? -8'sd128 : 8'(-div_mag_ff);
         rem_signed = 8'(-{3'b000, div_rem_ff});
      end else begin
         clicks_sat = (div_mag_ff > 8'd127) ? 8'sd127 : 8'(div_mag_ff);
         rem_signed = 8'({3'b000, div_rem_ff});
      end
   end

   always_comb begin
      item_in      = item_ff;
      ppc_in       = ppc_ff;
      inv_in       = inv_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      div_mag_in   = div_mag_ff;
      div_rem_in   = div_rem_ff;
      div_d_in     = div_d_ff;
      div_neg_in   = div_neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;

      if (csr_we) begin
         case (csr_index)
            qcc_pkg::CSR_PULSES_PER_CLICK: ppc_in = csr_wdata;
            qcc_pkg::CSR_INVERT_MASK:      inv_in = csr_wdata[1:0];
            default: ;
         endcase
      end

      if (cmd.capture) begin
         item_in = req_item;
      end

      if (cmd.update) begin
         case (item_ff.command)
            qcc_pkg::CMD_SAMPLE: begin
               if (enc_ok) begin
                  if (step_sum > 9'sd127) begin
                     count_in[idx] = 8'sd127;
                  end else if (step_sum < -9'sd128) begin
                     count_in[idx] = -8'sd128;
                  end else begin
                     count_in[idx] = 8'(step_sum);
                  end
                  phase_in[idx] = cur_phase;
               end
            end
            qcc_pkg::CMD_INIT: begin
               if (enc_ok) begin
                  phase_in[idx]  = cur_phase;
                  count_in[idx]  = '0;
                  remain_in[idx] = '0;
               end
            end
            qcc_pkg::CMD_READ: begin
               if (enc_ok) begin
                  count_in[idx] = '0;
               end
               div_mag_in = mag[7:0];
               div_rem_in = '0;
               div_neg_in = sum[8];
               div_d_in   = (ppc_ff == 5'd0) ? 5'd1 : ppc_ff;
            end
            default: ;
         endcase
      end

      if (cmd.div_step) begin
         div_mag_in = {div_mag_ff[6:0], qbit};
         div_rem_in = qbit ? 5'(trial - {1'b0, div_d_ff}) : trial[4:0];
      end

      if (cmd.finish) begin
         if (enc_ok) begin
            remain_in[idx] = rem_signed;
         end
         rsp_valid_in               = 1'b1;
         rsp_item_in.clicks         = clicks_sat;
         rsp_item_in.clicks_encoder = idx;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      div_mag_ff  <= div_mag_in;
      div_rem_ff  <= div_rem_in;
      div_d_ff    <= div_d_in;
      div_neg_ff  <= div_neg_in;
      rsp_item_ff <= rsp_item_in;
      if (reset) begin
         ppc_ff       <= qcc_pkg::PpcReset;
         inv_ff       <= qcc_pkg::InvertReset;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < qcc_pkg::NumEncoders; i++) begin
            phase_ff[i]  <= '0;
            count_ff[i]  <= '0;
            remain_ff[i] <= '0;
         end
      end else begin
         ppc_ff       <= ppc_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
      end
   end

   assign status.is_read  = (item_ff.command == qcc_pkg::CMD_READ);
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_item        = rsp_item_ff;

endmodule
`default_nettype wire

/* sv/quadrature_click_counter.sv */
// Top level of the quadrature click counter: controller, datapath and checks.
//
// Usage: each req_ item carries a command, an encoder index and the A/B pin
// levels. A sample item steps that encoder's saturating transition count
// (x4 quadrature decoding, direction flipped by invert_mask). An init item
// takes the pins as the new baseline phase and clears count and remainder.
// A read item divides remainder plus count by pulses_per_click and returns
// one rsp_ item with the whole clicks (truncated toward zero, saturated to
// int8) and the encoder index; the leftover is kept for the next read.
// Unknown commands are dropped without a result.
// Sequence: an item is taken while the block is idle, then the block is busy;
// sample and init pass through capture and update, a read through capture, sum,
// 8 divider steps in the shift-subtract unit and the load of the output register.
// The rsp_ output register holds its item while rsp_stall is high; the next
// req_ item is still taken, and a new read holds in its last step until the
// output register is free.
// csr_ writes land on the next edge; write them only while the block is idle.
// Reset (synchronous): pulses_per_click 4, invert_mask 3, all encoder state
// zero, no result pending.
`default_nettype none
`include "quadrature_click_counter_assert.svh"
module quadrature_click_counter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire qcc_pkg::req_item_type req_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output qcc_pkg::rsp_item_type      rsp_item,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [4:0]            csr_wdata
);

   qcc_pkg::qcc_cmd_type    cmd;
   qcc_pkg::qcc_status_type status;

   // Sequencer: owns the handshake on req_ and the divider step count.
   qcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Encoder state, registers, divider and result register.
   qcc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   // The controller issues at most one command per cycle.
   `QCC_ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd))
   // Capture only on an accepted input item.
   `QCC_ASSERT_IMPLIES(a_capture_on_accept, clock, reset, cmd.capture, req_valid && !req_stall)
   // Once an item is taken the block is busy in the next cycle.
   `QCC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // Never overwrite a result that is still waiting.
   `QCC_ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.finish, !(rsp_valid && rsp_stall))

endmodule
`default_nettype wire

/* tb/sv/quadrature_click_counter_test.sv */
// Self-checking testbench for the click counter: directed rows, then random spins and reads.
`timescale 1ns / 1ps
module quadrature_click_counter_test;

   // The package names three commands; the fourth code must be dropped by the block.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 16;    // covers a sample or init still in flight
   localparam int PHASE_ITEMS   = 36;
   localparam int SPIN_ITEMS    = 135;   // enough same-way steps to pin the count
   localparam int NUM_PHASES    = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DIR_ROWS      = 24;
   localparam int IDLE_ONE_SIDE = 58;
   localparam int IDLE_BOTH     = 36;

   // One row of the directed stimulus; want is used only where known is set.
   typedef struct packed {
      logic [1:0]        command;
      logic              encoder_index;
      logic              a_level;
      logic              b_level;
      logic              known;
      logic signed [7:0] want;
   } dir_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   qcc_pkg::req_item_type req_item  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   qcc_pkg::rsp_item_type rsp_item;
   logic                  csr_we    = 1'b0;
   logic                  csr_index = 1'b0;
   logic [4:0]            csr_wdata = '0;

   quadrature_click_counter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predicted encoder state and register copies, advanced on every accepted item.
   logic [1:0]        phase_seen   [qcc_pkg::NumEncoders];
   logic signed [7:0] pulse_count  [qcc_pkg::NumEncoders];
   logic signed [7:0] carry_pulses [qcc_pkg::NumEncoders];
   logic [4:0]        ppc_model    = qcc_pkg::PpcReset;
   logic [1:0]        invert_model = qcc_pkg::InvertReset;

   qcc_pkg::rsp_item_type clicks_due [$];   // predicted read results, oldest first
   qcc_pkg::rsp_item_type due_head;

   dir_row_type dir_tab [DIR_ROWS];

   bit send_idle = 1'b0;
   bit recv_idle = 1'b0;
   int idle_pct      = IDLE_ONE_SIDE;
   int items_sent    = 0;
   int reads_checked = 0;
   int count_clamps  = 0;
   int click_clamps  = 0;
   int errors        = 0;
   int cycles        = 0;

   // Forward rotation walks phases {B,A} 00 -> 10 -> 11 -> 01 -> 00, one count up per step.
   function automatic logic [1:0] phase_fwd(input logic [1:0] p);
      return {~p[0], p[1]};
   endfunction

   function automatic logic [1:0] phase_back(input logic [1:0] p);
      return {p[0], ~p[1]};
   endfunction

   function automatic logic signed [7:0] clamp_byte(input int v);
      if (v > 127) return 8'h7F;
      if (v < -128) return 8'h80;
      return v[7:0];
   endfunction

   function automatic qcc_pkg::req_item_type make_item(input logic [1:0] cmd, input logic e,
                                                       input logic a, input logic b);
      qcc_pkg::req_item_type it;
      it.command       = cmd;
      it.encoder_index = e;
      it.a_level       = a;
      it.b_level       = b;
      return it;
   endfunction

   // Advance the predicted state by one item; return 1 with the result when it is a read.
   function automatic bit predict_clicks(input qcc_pkg::req_item_type it,
                                         output qcc_pkg::rsp_item_type res);
      logic [1:0] ph;
      int         e;
      int         delta;
      int         divisor;
      int         sum;
      int         quo;
      ph = {it.b_level, it.a_level};
      e = int'(it.encoder_index);
      res = '0;
      predict_clicks = 1'b0;
      case (it.command)
         qcc_pkg::CMD_SAMPLE: begin
            // Only a neighbor phase counts; a hold or a diagonal jump adds nothing.
            if (phase_fwd(phase_seen[e]) == ph) delta = 1;
            else if (phase_back(phase_seen[e]) == ph) delta = -1;
            else delta = 0;
            if (invert_model[e]) delta = -delta;
            sum = int'(pulse_count[e]) + delta;
            if (sum > 127 || sum < -128) count_clamps++;
            pulse_count[e] = clamp_byte(sum);
            phase_seen[e] = ph;
         end
         qcc_pkg::CMD_INIT: begin
            phase_seen[e] = ph;
            pulse_count[e] = '0;
            carry_pulses[e] = '0;
         end
         qcc_pkg::CMD_READ: begin
            // A zero divisor behaves as one; division truncates toward zero.
            divisor = (ppc_model == 5'd0) ? 1 : int'(ppc_model);
            sum = int'(carry_pulses[e]) + int'(pulse_count[e]);
            quo = sum / divisor;
            carry_pulses[e] = clamp_byte(sum - quo * divisor);
            pulse_count[e] = '0;
            if (quo > 127 || quo < -128) click_clamps++;
            res.clicks = clamp_byte(quo);
            res.clicks_encoder = it.encoder_index;
            predict_clicks = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // Offer one item, wait for acceptance, then predict. A fixed value replaces the
   // predicted clicks for rows whose answer is plain from the spec.
   task automatic send_item(input qcc_pkg::req_item_type it, input logic fixed,
                            input logic signed [7:0] fixed_clicks);
      qcc_pkg::rsp_item_type res;
      if (send_idle) begin
         while ($urandom_range(0, 99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_clicks(it, res)) begin
         if (fixed) res.clicks = fixed_clicks;
         clicks_due.push_back(res);
      end
      items_sent++;
   endtask

   // Turn one encoder n well-formed steps in one direction.
   task automatic spin(input int e, input bit forward, input int n);
      logic [1:0] ph;
      repeat (n) begin
         ph = forward ? phase_fwd(phase_seen[e]) : phase_back(phase_seen[e]);
         send_item(make_item(qcc_pkg::CMD_SAMPLE, e[0], ph[0], ph[1]), 1'b0, '0);
      end
   endtask

   // Drop valid, let every pending read come back, then give in-flight work time to end.
   task automatic settle;
      req_valid <= 1'b0;
      @(posedge clock);
      while (clicks_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers on consecutive edges; only call while the block is idle.
   task automatic set_config(input logic [4:0] ppc_v, input logic [1:0] inv_v);
      csr_we    <= 1'b1;
      csr_index <= qcc_pkg::CSR_PULSES_PER_CLICK;
      csr_wdata <= ppc_v;
      @(posedge clock);
      // Upper data bits are don't-care for the mask; toggle them anyway.
      csr_index <= qcc_pkg::CSR_INVERT_MASK;
      csr_wdata <= {3'($urandom_range(0, 7)), inv_v};
      @(posedge clock);
      csr_we <= 1'b0;
      ppc_model = ppc_v;
      invert_model = inv_v;
      @(posedge clock);
   endtask

   // Receiver side: stall at random while the phase asks for it.
   always @(posedge clock) begin
      rsp_stall <= recv_idle && ($urandom_range(0, 99) < idle_pct);
   end

   // Result checker: compare each accepted result with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (clicks_due.size() == 0) begin
            errors++;
            $display("%0t: result with nothing pending: clicks %0d encoder %0d",
                     $time, rsp_item.clicks, rsp_item.clicks_encoder);
         end else begin
            due_head = clicks_due.pop_front();
            reads_checked++;
            if (rsp_item.clicks !== due_head.clicks) begin
               errors++;
               $display("%0t: clicks mismatch on encoder %0d: expected %0d, got %0d",
                        $time, due_head.clicks_encoder, due_head.clicks, rsp_item.clicks);
            end
            if (rsp_item.clicks_encoder !== due_head.clicks_encoder) begin
               errors++;
               $display("%0t: clicks_encoder mismatch: expected %0d, got %0d",
                        $time, due_head.clicks_encoder, rsp_item.clicks_encoder);
            end
         end
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d reads still pending",
                  $time, cycles, clicks_due.size());
         $display("** quadrature_click_counter: FAILED **");
         $finish;
      end
   end

   initial begin
      int  r;
      int  e;
      int  phase_start;
      bit  paused;
      for (int i = 0; i < qcc_pkg::NumEncoders; i++) begin
         phase_seen[i] = '0;
         pulse_count[i] = '0;
         carry_pulses[i] = '0;
      end

      // Directed rows, run with the reset settings (4 pulses per click, both inverted).
      dir_tab = '{
         '{qcc_pkg::CMD_READ,   1'b0, 1'b0, 1'b0, 1'b1, 8'sd0},  // nothing counted yet
         '{qcc_pkg::CMD_READ,   1'b1, 1'b0, 1'b0, 1'b1, 8'sd0},
         '{CMD_UNUSED,          1'b1, 1'b1, 1'b1, 1'b0, 8'sd0},  // unknown: no result
         '{qcc_pkg::CMD_READ,   1'b1, 1'b0, 1'b0, 1'b1, 8'sd0},  // and no state change
         '{qcc_pkg::CMD_INIT,   1'b0, 1'b0, 1'b0, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, 8'sd0},  // one full turn, inverted
         '{qcc_pkg::CMD_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0},  // hold: no step
         '{qcc_pkg::CMD_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0, 8'sd0},  // diagonal jump: no step
         '{qcc_pkg::CMD_READ,   1'b0, 1'b0, 1'b0, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_READ,   1'b0, 1'b0, 1'b0, 1'b0, 8'sd0},  // partial click kept
         '{qcc_pkg::CMD_INIT,   1'b0, 1'b1, 1'b1, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_READ,   1'b0, 1'b0, 1'b0, 1'b1, 8'sd0},  // init cleared the rest
         '{qcc_pkg::CMD_INIT,   1'b1, 1'b1, 1'b0, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b0, 8'sd0},  // reverse turn, encoder 1
         '{qcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, 1'b1, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_READ,   1'b1, 1'b0, 1'b0, 1'b0, 8'sd0},
         '{qcc_pkg::CMD_READ,   1'b1, 1'b0, 1'b0, 1'b0, 8'sd0}
      };

      // Hold reset, then release it once.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIR_ROWS; i++) begin
         send_item(make_item(dir_tab[i].command, dir_tab[i].encoder_index,
                             dir_tab[i].a_level, dir_tab[i].b_level),
                   dir_tab[i].known, dir_tab[i].want);
      end

      // Random phases, each with its own register setting and idling pattern.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         settle;
         idle_pct = IDLE_ONE_SIDE;
         case (ph)
            0: begin  // reset settings, no idling
               send_idle = 1'b0;
               recv_idle <= 1'b0;
            end
            1: begin
               set_config(5'd16, 2'd0);
               send_idle = 1'b1;
               recv_idle <= 1'b0;
            end
            2: begin  // widest divisor leaves large remainders behind
               set_config(5'd31, 2'd1);
               send_idle = 1'b0;
               recv_idle <= 1'b1;
            end
            3: begin
               set_config(5'd1, 2'd2);
               send_idle = 1'b1;
               recv_idle <= 1'b1;
               idle_pct  = IDLE_BOTH;
            end
            4: begin  // zero divisor acts as one
               set_config(5'd0, 2'd3);
               send_idle = 1'b0;
               recv_idle <= 1'b0;
            end
            default: begin
               set_config(5'($urandom_range(1, 16)), 2'($urandom_range(0, 3)));
               send_idle = 1'($urandom_range(0, 1));
               recv_idle <= 1'($urandom_range(0, 1));
            end
         endcase

         // Pin both counts before any read: encoder 0 up to the top, encoder 1
         // (inverted) down to the bottom; a leftover remainder can push the read past int8.
         if (ph == 3) begin
            spin(0, 1'b1, SPIN_ITEMS);
            send_item(make_item(qcc_pkg::CMD_READ, 1'b0, 1'b0, 1'b0), 1'b0, '0);
            spin(1, 1'b1, SPIN_ITEMS);
            send_item(make_item(qcc_pkg::CMD_READ, 1'b1, 1'b0, 1'b0), 1'b0, '0);
         end

         phase_start = items_sent;
         paused = 1'b0;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            // Once, halfway through, hold the sender until every read is back.
            if (ph == 1 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               settle;
               paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            e = $urandom_range(0, 1);
            if (r < 50) begin
               spin(e, 1'($urandom_range(0, 1)), $urandom_range(1, 8));
            end else if (r < 56) begin
               send_item(make_item(qcc_pkg::CMD_SAMPLE, e[0], phase_seen[e][0],
                                   phase_seen[e][1]), 1'b0, '0);
            end else if (r < 80) begin
               send_item(make_item(qcc_pkg::CMD_READ, e[0], 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))), 1'b0, '0);
            end else if (r < 86) begin
               send_item(make_item(qcc_pkg::CMD_INIT, e[0], 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))), 1'b0, '0);
            end else if (r < 95) begin
               // noise: any pin pair, jumps included
               send_item(make_item(qcc_pkg::CMD_SAMPLE, e[0], 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))), 1'b0, '0);
            end else begin
               send_item(make_item(CMD_UNUSED, e[0], 1'($urandom_range(0, 1)),
                                   1'($urandom_range(0, 1))), 1'b0, '0);
            end
         end
      end

      settle;
      $display("Covered %0d items with %0d click reads checked over %0d register settings;",
               items_sent, reads_checked, NUM_PHASES);
      $display("%0d count updates hit a limit and %0d reads clamped the click value.",
               count_clamps, click_clamps);
      if (errors == 0) begin
         $display("** quadrature_click_counter: PASSED **");
      end else begin
         $display("** quadrature_click_counter: FAILED **");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/qcc_pkg.sv
sv/qcc_ctrl.sv
sv/qcc_datapath.sv
sv/quadrature_click_counter.sv
tb/sv/quadrature_click_counter_test.sv
